// File: rtl/svp_pkg.sv
// ----------------------------------------------------------------------------
// svp_pkg: shared types and codes for the vector permute unit
// Operation codes, arrangement codes, the decoded layout struct and the
// byte vector types used by the decoder, the byte lanes and the top level.
// ----------------------------------------------------------------------------
package svp_pkg;

	localparam int VecBytes = 16;
	localparam int CatBytes = 2 * VecBytes;
	localparam int ByteIdxW = $clog2(VecBytes);
	localparam int CatIdxW  = $clog2(CatBytes);

	// operation codes
	localparam logic [2:0] OP_EXT  = 3'd0;
	localparam logic [2:0] OP_ZIP1 = 3'd1;
	localparam logic [2:0] OP_ZIP2 = 3'd2;
	localparam logic [2:0] OP_UZP1 = 3'd3;
	localparam logic [2:0] OP_UZP2 = 3'd4;
	localparam logic [2:0] OP_TRN1 = 3'd5;
	localparam logic [2:0] OP_TRN2 = 3'd6;

	// arrangement codes
	localparam logic [3:0] ARR_8B  = 4'd1;
	localparam logic [3:0] ARR_16B = 4'd2;
	localparam logic [3:0] ARR_4H  = 4'd3;
	localparam logic [3:0] ARR_8H  = 4'd4;
	localparam logic [3:0] ARR_2S  = 4'd5;
	localparam logic [3:0] ARR_4S  = 4'd6;
	localparam logic [3:0] ARR_1D  = 4'd7;
	localparam logic [3:0] ARR_2D  = 4'd8;

	// decoded lane layout: element size and element count as log2
	typedef struct packed {
		logic       ok;
		logic [1:0] esz_log;
		logic [2:0] cnt_log;
	} layout_t;

	typedef logic [CatBytes-1:0][7:0] cat_bytes_t;
	typedef logic [VecBytes-1:0][7:0] vec_bytes_t;

endpackage

// File: rtl/svp_decode.sv
// ----------------------------------------------------------------------------
// svp_decode: arrangement decoder
// Turns the arrangement code into element size and count; flags bad codes.
// ----------------------------------------------------------------------------
module svp_decode import svp_pkg::*; (
	input  logic [3:0] arrangement,
	output layout_t    layout
);

	always_comb begin
		layout = '0;
		unique case (arrangement)
			ARR_8B:  layout = '{ok: 1'b1, esz_log: 2'd0, cnt_log: 3'd3};
			ARR_16B: layout = '{ok: 1'b1, esz_log: 2'd0, cnt_log: 3'd4};
			ARR_4H:  layout = '{ok: 1'b1, esz_log: 2'd1, cnt_log: 3'd2};
			ARR_8H:  layout = '{ok: 1'b1, esz_log: 2'd1, cnt_log: 3'd3};
			ARR_2S:  layout = '{ok: 1'b1, esz_log: 2'd2, cnt_log: 3'd1};
			ARR_4S:  layout = '{ok: 1'b1, esz_log: 2'd2, cnt_log: 3'd2};
			ARR_1D:  layout = '{ok: 1'b1, esz_log: 2'd3, cnt_log: 3'd0};
			ARR_2D:  layout = '{ok: 1'b1, esz_log: 2'd3, cnt_log: 3'd1};
			default: layout = '0;
		endcase
	end

endmodule

// File: rtl/svp_lane.sv
// ----------------------------------------------------------------------------
// svp_lane: one result byte lane
// Works out which byte of right:left feeds this result byte and selects it.
// ----------------------------------------------------------------------------
module svp_lane import svp_pkg::*; (
	input  logic [ByteIdxW-1:0] lane_idx,
	input  logic [2:0]          op,
	input  layout_t             layout,
	input  logic [7:0]          byte_offset,
	input  cat_bytes_t          cat,
	output logic [7:0]          lane_byte
);

	logic [ByteIdxW-1:0] elem;
	logic [ByteIdxW-1:0] sub;
	logic [ByteIdxW:0]   count;
	logic [ByteIdxW:0]   half;
	logic [ByteIdxW-1:0] src_elem;
	logic                second_src;
	logic [ByteIdxW-1:0] src_byte;
	logic [8:0]          ext_idx;
	logic [CatIdxW-1:0]  pick;
	logic                zero;

	always_comb begin
		elem  = lane_idx >> layout.esz_log;
		sub   = lane_idx & ((ByteIdxW'(1) << layout.esz_log) - ByteIdxW'(1));
		count = (ByteIdxW+1)'(1) << layout.cnt_log;
		half  = count >> 1;
		src_elem   = '0;
		second_src = 1'b0;
		unique case (op)
			OP_ZIP1, OP_ZIP2: begin
				src_elem   = ((op == OP_ZIP2) ? half[ByteIdxW-1:0] : '0) + (elem >> 1);
				second_src = elem[0];
			end
			OP_UZP1, OP_UZP2: begin
				src_elem   = ((elem & (half[ByteIdxW-1:0] - ByteIdxW'(1))) << 1)
					| ByteIdxW'(op == OP_UZP2);
				second_src = {1'b0, elem} >= half;
			end
			default: begin
				// TRN1, TRN2 and the unlisted code, which acts as TRN1
				src_elem   = {elem[ByteIdxW-1:1], (op == OP_TRN2)};
				second_src = elem[0];
			end
		endcase
		src_byte = (src_elem << layout.esz_log) | sub;
		ext_idx  = {5'd0, lane_idx} + {1'b0, byte_offset};

		if (op == OP_EXT) begin
			pick = ext_idx[CatIdxW-1:0];
			zero = !layout.ok || (ext_idx >= 9'(CatBytes));
		end else begin
			pick = {second_src, src_byte};
			// drop single-lane layouts and lanes past the element count
			zero = !layout.ok || (layout.cnt_log == 3'd0) || ({1'b0, elem} >= count);
		end
		lane_byte = zero ? 8'd0 : cat[pick];
	end

endmodule

// File: rtl/simd_vector_permute_unit.sv
// ----------------------------------------------------------------------------
// simd_vector_permute_unit: 128-bit EXT / ZIP / UZP / TRN permute
// Sixteen byte lanes each pick one source byte; the results merge into one
// registered 128-bit word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one word per accepted cycle:
//   op, arrangement, the left and right vectors and byte_offset.
//   Output channel: out_valid / out_stall carry result_lo / result_hi.
//   A word is taken at a rising edge with valid high and stall low.
//   The decoder and the sixteen byte lanes are pure selection logic in
//   front of a single output register.
//   Throughput: one word per cycle while out_stall is low. A new word is
//   accepted in the same cycle that the held result is taken; no bubbles.
//   Receiver stall: the output register holds its word and in_stall is
//   raised only while a result is waiting and out_stall is high.
//   Reset: arst_n clears out_valid; the result registers are not reset.
// ----------------------------------------------------------------------------
module simd_vector_permute_unit import svp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [3:0]  arrangement,
	input  logic [63:0] left_lo,
	input  logic [63:0] left_hi,
	input  logic [63:0] right_lo,
	input  logic [63:0] right_hi,
	input  logic [7:0]  byte_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_lo,
	output logic [63:0] result_hi
);

	layout_t    layout;
	cat_bytes_t cat;
	vec_bytes_t lane_bytes;
	logic       advance;
	logic       out_valid_q;
	logic [63:0] result_lo_q;
	logic [63:0] result_hi_q;

	// byte 0 of the concatenation is bits 7..0 of left_lo, byte 16 starts right
	assign cat = {right_hi, right_lo, left_hi, left_lo};

	svp_decode u_decode (
		.arrangement (arrangement),
		.layout      (layout)
	);

	for (genvar g = 0; g < VecBytes; g++) begin : g_lane
		svp_lane u_lane (
			.lane_idx    (ByteIdxW'(g)),
			.op          (op),
			.layout      (layout),
			.byte_offset (byte_offset),
			.cat         (cat),
			.lane_byte   (lane_bytes[g])
		);
	end

	// advance when the output register is empty or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_valid;
		end
	end

	// merge the lane bytes into the held result word
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			result_lo_q <= lane_bytes[VecBytes/2-1:0];
			result_hi_q <= lane_bytes[VecBytes-1:VecBytes/2];
		end
	end

	assign out_valid = out_valid_q;
	assign result_lo = result_lo_q;
	assign result_hi = result_hi_q;

endmodule
